### design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge once reset is released
`define ASSERT_RUN(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALL(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### design/ttip_pkg.sv
`timescale 1ns / 1ps

package ttip_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int END_BITS    = 16;

    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [5:0] MAX_BASE = 6'd36;
    localparam logic [6:0] NO_DIGIT = 7'd64;

    localparam logic [7:0] REG_NUMBER_BASE   = 8'd0;
    localparam logic [7:0] REG_SIGNED_RESULT = 8'd1;
    localparam logic [7:0] REG_RESULT_BITS   = 8'd2;
    localparam logic [7:0] REG_CHECK_RANGE   = 8'd3;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_START,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef logic [OFFSET_BITS-1:0] pos_t;

    function automatic pos_t pos_inc(input pos_t p);
        pos_inc = (&p) ? p : p + pos_t'(1);
    endfunction

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] l;
        l = c | CASE_BIT;
        if (c >= "0" && c <= "9")
            digit_of = 7'(c - 8'h30);
        else if (l >= "a" && l <= "z")
            digit_of = 7'(l - 8'h61) + 7'd10;
        else
            digit_of = NO_DIGIT;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

### design/text_to_integer_parser_unit.sv
`timescale 1ns / 1ps
// a terminating character waits in the input register; its result is written to the output register when it advances
// throughput: one character per cycle while the output register is not stalled, set by
// the state loop through the 64 x 6 bit multiply-add of the accumulator
// results leave through an output register; a full, stalled output register holds
// back only the character in the input register
// reset (rst_n low, asynchronous) clears the parse state and loads the register defaults

`include "assert_macros.svh"

module text_to_integer_parser_unit
    import ttip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic [0:0]  s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // value[63:0], end_offset[79:64]
    output logic [1:0]  m_tuser,   // range_error, no_digits
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [5:0] number_base_reg;
    logic       signed_result_reg;
    logic [6:0] result_bits_reg;
    logic       check_range_reg;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       first_reg;

    phase_t      phase_reg,  phase_next;
    logic        neg_reg,    neg_next;
    logic [5:0]  base_reg,   base_next;
    logic [63:0] acc_reg,    acc_next;
    logic        ovf_reg,    ovf_next;
    pos_t        pos_reg,    pos_next;

    logic          out_valid_reg;
    logic [63:0]   out_value_reg;
    logic [END_BITS-1:0] out_end_reg;
    logic          out_rerr_reg;
    logic          out_nod_reg;

    logic advance;
    logic s_accept;

    // state as seen by the item in the input register
    phase_t      ph_e;
    logic        neg_e;
    logic [5:0]  base_e;
    logic [63:0] acc_e;
    logic        ovf_e;
    pos_t        pos_e;

    logic [6:0]  dig;
    logic [5:0]  sel_base;
    logic [5:0]  start_base;
    logic        do_start;
    logic        do_digit;
    logic        two_steps;
    logic [69:0] mac;

    logic        emit;
    logic [63:0] e_value;
    logic [END_BITS-1:0] e_end;
    logic        e_rerr;
    logic        e_nod;

    logic        w32;
    logic [63:0] mask;
    logic [63:0] half;
    logic [63:0] lim;
    logic [63:0] sval;
    logic        fin_bad;
    logic [OFFSET_BITS+END_BITS-1:0] pos_ext;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_end_reg, out_value_reg};
    assign m_tuser  = {out_nod_reg, out_rerr_reg};

    // result of finishing the current number
    always_comb
    begin
        w32     = (result_bits_reg == 7'd32);
        mask    = w32 ? 64'h0000_0000_FFFF_FFFF : '1;
        half    = w32 ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
        lim     = signed_result_reg ? (neg_e ? half : half - 64'd1) : mask;
        sval    = neg_e ? (64'd0 - acc_e) : acc_e;
        fin_bad = check_range_reg && (ovf_e || acc_e > lim);
        pos_ext = {{END_BITS{1'b0}}, pos_e};
    end

    always_comb
    begin
        ph_e   = first_reg ? PH_SKIP : phase_reg;
        neg_e  = first_reg ? 1'b0 : neg_reg;
        base_e = first_reg ? 6'd0 : base_reg;
        acc_e  = first_reg ? 64'd0 : acc_reg;
        ovf_e  = first_reg ? 1'b0 : ovf_reg;
        pos_e  = first_reg ? pos_t'(0) : pos_reg;

        phase_next = ph_e;
        neg_next   = neg_e;
        base_next  = base_e;
        acc_next   = acc_e;
        ovf_next   = ovf_e;
        pos_next   = pos_e;

        emit    = 1'b0;
        e_value = 64'd0;
        e_end   = '0;
        e_rerr  = 1'b0;
        e_nod   = 1'b0;

        dig        = digit_of(ch_reg);
        sel_base   = base_e;
        start_base = base_e;
        do_start   = 1'b0;
        do_digit   = 1'b0;
        two_steps  = 1'b0;

        case (ph_e)
            PH_SKIP:
            begin
                if (is_space(ch_reg))
                begin
                    pos_next = pos_inc(pos_e);
                end
                else
                begin
                    base_next = number_base_reg;
                    if (number_base_reg == 6'd1 || number_base_reg > MAX_BASE)
                    begin
                        emit       = 1'b1;
                        e_nod      = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else if (ch_reg == "-" || ch_reg == "+")
                    begin
                        neg_next   = (ch_reg == "-");
                        pos_next   = pos_inc(pos_e);
                        phase_next = PH_START;
                    end
                    else
                    begin
                        do_start   = 1'b1;
                        start_base = number_base_reg;
                    end
                end
            end
            PH_START:
            begin
                do_start = 1'b1;
            end
            PH_ZERO:
            begin
                if ((ch_reg | CASE_BIT) == "x")
                begin
                    base_next  = 6'd16;
                    phase_next = PH_XSEEN;
                end
                else
                begin
                    sel_base  = (base_e == 6'd0) ? 6'd8 : base_e;
                    base_next = sel_base;
                    do_digit  = 1'b1;
                end
            end
            PH_XSEEN:
            begin
                do_digit  = 1'b1;
                two_steps = 1'b1;
            end
            PH_DIGITS:
            begin
                do_digit = 1'b1;
            end
            default:
            begin
                phase_next = ph_e;
            end
        endcase

        // a prefix zero only counts in base 0 or 16
        if (do_start && !((start_base == 6'd0 || start_base == 6'd16) && ch_reg == "0"))
            sel_base = (start_base == 6'd0) ? 6'd10 : start_base;

        mac = 70'(acc_e) * 70'(sel_base) + 70'(dig);

        if (do_start)
        begin
            if ((start_base == 6'd0 || start_base == 6'd16) && ch_reg == "0")
            begin
                pos_next   = pos_inc(pos_e);
                base_next  = start_base;
                phase_next = PH_ZERO;
            end
            else
            begin
                base_next = sel_base;
                if (dig >= 7'(sel_base))
                begin
                    emit       = 1'b1;
                    e_nod      = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next   = mac[63:0];
                    ovf_next   = ovf_e | (|mac[69:64]);
                    pos_next   = pos_inc(pos_e);
                    phase_next = PH_DIGITS;
                end
            end
        end

        if (do_digit)
        begin
            if (dig >= 7'(sel_base))
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
                if (fin_bad)
                begin
                    e_rerr = 1'b1;
                end
                else
                begin
                    e_value = sval & mask;
                    e_end   = pos_ext[END_BITS-1:0];
                end
            end
            else
            begin
                acc_next   = mac[63:0];
                ovf_next   = ovf_e | (|mac[69:64]);
                pos_next   = two_steps ? pos_inc(pos_inc(pos_e)) : pos_inc(pos_e);
                phase_next = PH_DIGITS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg   <= 6'd10;
            signed_result_reg <= 1'b1;
            result_bits_reg   <= 7'd64;
            check_range_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUMBER_BASE:   number_base_reg   <= cfg_data[5:0];
                REG_SIGNED_RESULT: signed_result_reg <= cfg_data[0];
                REG_RESULT_BITS:   result_bits_reg   <= cfg_data[6:0];
                REG_CHECK_RANGE:   check_range_reg   <= cfg_data[0];
                default:           number_base_reg   <= number_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            base_reg      <= 6'd0;
            acc_reg       <= 64'd0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ch_reg    <= s_tdata;
            first_reg <= s_tuser[0];
        end
        if (advance && emit)
        begin
            out_value_reg <= e_value;
            out_end_reg   <= e_end;
            out_rerr_reg  <= e_rerr;
            out_nod_reg   <= e_nod;
        end
    end

    // a stalled result with a character waiting holds the input side
    `ASSERT_RUN(a_stall_back, in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
    // a range error carries a zero value and offset
    `ASSERT_RUN(a_rerr_zero, out_valid_reg && out_rerr_reg |-> out_value_reg == 64'd0 &&
        out_end_reg == '0 && !out_nod_reg)
    // no digits gives zero at offset zero
    `ASSERT_RUN(a_nod_zero, out_valid_reg && out_nod_reg |-> out_value_reg == 64'd0 &&
        out_end_reg == '0)
    // after a result the parse stays done until a new string
    `ASSERT_RUN(a_done_after, advance && emit |=> phase_reg == PH_DONE)
    `ASSERT_ALL(a_reset_empty, !rst_n |=> !m_tvalid)

endmodule

### bench/text_to_integer_parser_unit_test.sv
`timescale 1ns / 1ps

module text_to_integer_parser_unit_test;
    import ttip_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        logic        range_error;
        logic        no_digits;
    } parse_result_t;

    class parse_scoreboard;
        logic [5:0]    base_reg;
        logic          sign_reg;
        logic [6:0]    bits_reg;
        logic          check_reg;
        phase_t        ph;
        logic          neg;
        logic [5:0]    radix;
        logic [63:0]   acc;
        logic          wrapped;
        pos_t          pos;
        parse_result_t expected_q[$];
        int            errors;

        function new();
            base_reg  = 6'd10;
            sign_reg  = 1'b1;
            bits_reg  = 7'd64;
            check_reg = 1'b1;
            errors    = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            ph      = PH_SKIP;
            neg     = 1'b0;
            radix   = '0;
            acc     = '0;
            wrapped = 1'b0;
            pos     = '0;
        endfunction

        function void set_register(input logic [7:0] idx, input logic [7:0] data);
            case (idx)
                REG_NUMBER_BASE:   base_reg  = data[5:0];
                REG_SIGNED_RESULT: sign_reg  = data[0];
                REG_RESULT_BITS:   bits_reg  = data[6:0];
                REG_CHECK_RANGE:   check_reg = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [6:0] char_digit(input logic [7:0] c);
            logic [7:0] low;
            low = c | CASE_BIT;
            if (c >= "0" && c <= "9")
                return 7'(c - "0");
            if (low >= "a" && low <= "z")
                return 7'(low - "a") + 7'd10;
            return NO_DIGIT;
        endfunction

        function void bump();
            if (!(&pos))
                pos = pos + pos_t'(1);
        endfunction

        function void post(input logic [63:0] v, input logic [15:0] e,
                           input logic re, input logic nd);
            parse_result_t r;
            r.value       = v;
            r.end_offset  = e;
            r.range_error = re;
            r.no_digits   = nd;
            expected_q.push_back(r);
            ph = PH_DONE;
        endfunction

        // sticky flag once the product passes 64 bits
        function void accumulate(input logic [6:0] d);
            logic [70:0] wide;
            wide = 71'(acc) * 71'(radix) + 71'(d);
            if (wide[70:64] != '0)
                wrapped = 1'b1;
            acc = wide[63:0];
        endfunction

        function void conclude();
            logic [63:0] mask;
            logic [63:0] half;
            logic [63:0] lim;
            logic [63:0] sval;
            mask = (bits_reg == 7'd32) ? 64'h0000_0000_FFFF_FFFF : '1;
            half = (bits_reg == 7'd32) ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
            sval = neg ? (64'd0 - acc) : acc;
            if (check_reg)
            begin
                lim = sign_reg ? (half - (neg ? 64'd0 : 64'd1)) : mask;
                if (wrapped || acc > lim)
                begin
                    post('0, '0, 1'b1, 1'b0);
                    return;
                end
            end
            post(sval & mask, 16'(pos), 1'b0, 1'b0);
        endfunction

        function void take_digit(input logic [7:0] c);
            logic [6:0] d;
            d = char_digit(c);
            if (d >= 7'(radix))
                conclude();
            else
            begin
                accumulate(d);
                bump();
            end
        endfunction

        function void take_start(input logic [7:0] c);
            logic [6:0] d;
            if ((radix == 6'd0 || radix == 6'd16) && c == "0")
            begin
                bump();
                ph = PH_ZERO;
                return;
            end
            if (radix == 6'd0)
                radix = 6'd10;
            d = char_digit(c);
            if (d >= 7'(radix))
                post('0, '0, 1'b0, 1'b1);
            else
            begin
                accumulate(d);
                bump();
                ph = PH_DIGITS;
            end
        endfunction

        function void note_char(input logic [7:0] c, input logic f);
            logic [6:0] d;
            if (f)
                clear_parse();
            case (ph)
                PH_SKIP:
                begin
                    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
                        bump();
                    else
                    begin
                        radix = base_reg;
                        if (radix == 6'd1 || radix > MAX_BASE)
                            post('0, '0, 1'b0, 1'b1);
                        else if (c == "-" || c == "+")
                        begin
                            neg = (c == "-");
                            bump();
                            ph = PH_START;
                        end
                        else
                        begin
                            ph = PH_START;
                            take_start(c);
                        end
                    end
                end
                PH_START: take_start(c);
                PH_ZERO:
                begin
                    if ((c | CASE_BIT) == "x")
                    begin
                        radix = 6'd16;
                        ph = PH_XSEEN;
                    end
                    else
                    begin
                        if (radix == 6'd0)
                            radix = 6'd8;
                        ph = PH_DIGITS;
                        take_digit(c);
                    end
                end
                PH_XSEEN:
                begin
                    d = char_digit(c);
                    if (d >= 7'(radix))
                        conclude();
                    else
                    begin
                        // the x before this digit is counted here
                        accumulate(d);
                        bump();
                        bump();
                        ph = PH_DIGITS;
                    end
                end
                PH_DIGITS: take_digit(c);
                default: ;
            endcase
        endfunction

        task flag_mismatch(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(input logic [79:0] td, input logic [1:0] tu);
            parse_result_t e;
            if (expected_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result, value %h", td[63:0]));
                return;
            end
            e = expected_q.pop_front();
            if (td[63:0] !== e.value)
                flag_mismatch($sformatf("value %h, expected %h", td[63:0], e.value));
            if (td[79:64] !== e.end_offset)
                flag_mismatch($sformatf("end_offset %0d, expected %0d", td[79:64],
                                        e.end_offset));
            if (tu[0] !== e.range_error)
                flag_mismatch($sformatf("range_error %b, expected %b", tu[0], e.range_error));
            if (tu[1] !== e.no_digits)
                flag_mismatch($sformatf("no_digits %b, expected %b", tu[1], e.no_digits));
        endtask

        task flush_check();
            if (expected_q.size() != 0)
                flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // ch
    logic [0:0]  s_tuser   = '0;    // first
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;           // value[63:0], end_offset[79:64]
    logic [1:0]  m_tuser;           // range_error, no_digits
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    int send_idle  = 0;
    int recv_stall = 0;

    parse_scoreboard sb = new();

    text_to_integer_parser_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic f);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_char(c, f);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic f);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], f && (i == 0));
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
    endtask

    // unused upper data bits are randomised
    task automatic set_config(input logic [5:0] b, input logic sg, input logic [6:0] w,
                              input logic k);
        write_reg(REG_NUMBER_BASE,   {2'($urandom), b});
        write_reg(REG_SIGNED_RESULT, {7'($urandom), sg});
        write_reg(REG_RESULT_BITS,   {1'($urandom), w});
        write_reg(REG_CHECK_RANGE,   {7'($urandom), k});
        cfg_valid <= 1'b0;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // a string without a result may still be in the pipeline
    task automatic wait_idle();
        hold_until_drained();
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [63:0] limit_value();
        case ($urandom_range(7))
            0: return 64'h0000_0000_7FFF_FFFF;
            1: return 64'h0000_0000_8000_0000;
            2: return 64'h0000_0000_FFFF_FFFF;
            3: return 64'h0000_0001_0000_0000;
            4: return 64'h7FFF_FFFF_FFFF_FFFF;
            5: return 64'h8000_0000_0000_0000;
            6: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return 64'h0000_0000_0000_0000;
        endcase
    endfunction

    task automatic send_random_string(output int sent);
        logic [7:0]  txt[$];
        logic [7:0]  rev[$];
        logic [7:0]  c;
        logic [63:0] mag;
        int          kind;
        int          fmt;
        int          n;
        int          r;
        bit          cut;
        sent = 0;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // raw noise, any byte, any start flag
            n = $urandom_range(1, 6);
            repeat (n) send_char(8'($urandom), $urandom_range(3) == 0);
            sent = n;
            return;
        end
        cut = (kind < 14);
        r = $urandom_range(9);
        n = (r < 6) ? 0 : r - 5;
        repeat (n)
        begin
            r = $urandom_range(5);
            txt.push_back((r == 5) ? 8'h20 : 8'(8'h09 + r));
        end
        r = $urandom_range(2);
        if (r == 1)
            txt.push_back("+");
        else if (r == 2)
            txt.push_back("-");
        fmt = sb.base_reg;
        if (fmt == 0)
        begin
            r = $urandom_range(2);
            if (r == 0)
            begin
                txt.push_back("0");
                txt.push_back($urandom_range(1) ? "x" : "X");
                fmt = 16;
            end
            else if (r == 1)
            begin
                txt.push_back("0");
                fmt = 8;
            end
            else
                fmt = 10;
        end
        else if (fmt == 16 && $urandom_range(2) == 0)
        begin
            txt.push_back("0");
            txt.push_back($urandom_range(1) ? "x" : "X");
        end
        if (fmt == 1 || fmt > 36)
            fmt = 36;
        if ($urandom_range(99) < 35)
        begin
            // numbers around the 32 and 64 bit limits
            mag = limit_value() + 64'($urandom_range(4)) - 64'd2;
            do
            begin
                rev.push_front(digit_char(int'(mag % 64'(fmt))));
                mag = mag / 64'(fmt);
            end
            while (mag != 0);
            if ($urandom_range(5) == 0)
                rev.push_back(digit_char($urandom_range(fmt - 1)));
            foreach (rev[i])
                txt.push_back(rev[i]);
        end
        else
        begin
            r = $urandom_range(99);
            n = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 12) :
                (r < 95) ? $urandom_range(13, 25) : $urandom_range(26, 70);
            repeat (n) txt.push_back(digit_char($urandom_range(fmt - 1)));
        end
        if (!cut)
        begin
            c = $urandom_range(1) ? 8'h00 : 8'($urandom);
            if (sb.char_digit(c) < fmt)
                c = 8'h00;
            txt.push_back(c);
        end
        foreach (txt[i])
            send_char(txt[i], i == 0);
        sent = txt.size();
        // trailing characters, normally ignored
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) send_char(8'($urandom), 1'b0);
    endtask

    initial
    begin
        int done;
        int n;
        int r;
        bit paused;
        logic [5:0] b;
        logic [6:0] w;
        paused = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_char(8'h0B, 1'b1);
        send_text("-42:", 1'b0);
        send_text("Z", 1'b1);
        send_text("+", 1'b1);
        send_char(8'h00, 1'b0);
        // a new start drops the unfinished string
        send_text("12", 1'b1);
        send_text("9", 1'b1);
        send_char(8'h00, 1'b0);
        send_char("5", 1'b0);
        send_char(8'hFF, 1'b0);
        wait_idle();
        set_config(6'd0, 1'b1, 7'd64, 1'b1);
        send_text("0x", 1'b1);
        send_char(8'h00, 1'b0);
        send_text("0178", 1'b1);
        send_text("0Xg", 1'b1);
        wait_idle();
        set_config(6'd36, 1'b0, 7'd32, 1'b0);
        send_text("z@", 1'b1);
        send_text("[", 1'b1);
        wait_idle();
        set_config(6'd1, 1'b1, 7'd64, 1'b1);
        send_text(" 5", 1'b1);
        wait_idle();
        set_config(6'd37, 1'b1, 7'd64, 1'b1);
        send_text("a", 1'b1);

        for (int seg = 0; seg < 9; seg++)
        begin
            wait_idle();
            case (seg)
                0: set_config(6'd10, 1'b1, 7'd64, 1'b1);
                1: set_config(6'd0,  1'b0, 7'd32, 1'b1);
                2: set_config(6'd36, 1'b1, 7'd32, 1'b0);
                3: set_config(6'd2,  1'b0, 7'd64, 1'b1);
                4: set_config(6'd16, 1'b1, 7'd32, 1'b1);
                5: set_config(6'd0,  1'b1, 7'd127, 1'b0);
                6: set_config(6'd8,  1'b0, 7'd32, 1'b1);
                default:
                begin
                    r = $urandom_range(9);
                    b = (r == 0) ? 6'($urandom) : 6'($urandom_range(36));
                    r = $urandom_range(2);
                    w = (r == 0) ? 7'd32 : (r == 1) ? 7'd64 : 7'($urandom);
                    set_config(b, 1'($urandom), w, 1'($urandom));
                end
            endcase
            send_idle  = (seg < 3) ? 27 : (seg < 6) ? 74 : 0;
            recv_stall = (seg < 3) ? 74 : (seg < 6) ? 27 : 0;
            done = 0;
            while (done < 120)
            begin
                send_random_string(n);
                done += n;
                if (seg == 4 && !paused && done >= 60)
                begin
                    hold_until_drained();
                    paused = 1;
                end
            end
        end

        hold_until_drained();
        repeat (8) @(negedge clk);
        sb.flush_check();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ttip_pkg.sv
design/text_to_integer_parser_unit.sv
bench/text_to_integer_parser_unit_test.sv
